### hdl/motor_feedback_multiturn_decoder_macros.svh
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_macros
// assertion shorthands used by the checker file mfmd_chk
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODER_MACROS_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODER_MACROS_SVH

// clocked assertion, off while reset is low
`define MFMD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same on the usual clock and reset names
`define MFMD_ASSERT_CLK(label, prop, msg) \
    `MFMD_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

### hdl/mfmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_pkg
// types and fixed constants of the motor feedback decoder
// ----------------------------------------------------------------------------
package mfmd_pkg;

    localparam int CODE_BITS  = 13;
    localparam int TURN_OUT_W = 16;
    localparam int ACC_W      = 128;
    localparam int M_W        = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI_TURN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd4;

    // motor types
    localparam logic [1:0] MT_SMALL = 2'd0;
    localparam logic [1:0] MT_LARGE = 2'd1;

    localparam logic signed [13:0] JUMP_LIM   = 14'sd4096;
    localparam int                 ANG_OFFSET = 4095;
    localparam int                 ANG_SH     = 42;
    localparam int                 RATE_SH    = 40;

    localparam logic [47:0] ANG_HALF  = 48'h8000_0000_0000;
    localparam logic [31:0] OUT_HALF  = 32'h8000_0000;

    // 2*pi scaled, pi/30 scaled
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [36:0] OMEGA_Q40 = 37'd115140588411;

    // torque per raw unit, scaled by 2^48
    localparam logic [63:0] TQ_SMALL  = (((64'd1 << 49) / 64'd200000) + 64'd1) / 64'd2;
    localparam logic [63:0] TQ_LARGE  = (((64'd1122 << 35) / 64'd3591) + 64'd1) / 64'd2;
    localparam logic [63:0] TQ_GIMBAL = (((64'd2223 << 35) / 64'd1000) + 64'd1) / 64'd2;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic       init;     // load accumulator with rounding bit
        logic       rnd;
        logic [5:0] rnd_pos;
        logic       mul;      // form one 32x32 partial product
        logic       add;      // add registered partial into accumulator
        logic [1:0] pp;       // bit 0 picks half of a, bit 1 half of b
    } t_mac_ctl;

    function automatic t_word torque_factor(input logic [1:0] mtype);
        t_word f;
        case (mtype)
            MT_SMALL: f = TQ_SMALL;
            MT_LARGE: f = TQ_LARGE;
            default:  f = TQ_GIMBAL;
        endcase
        return f;
    endfunction

endpackage

### hdl/mfmd_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_mac
// shared 32x32 multiplier with registered product and wide accumulator
// ----------------------------------------------------------------------------
module mfmd_mac
    import mfmd_pkg::*;
(
    input  logic             i_clk,
    input  t_mac_ctl         i_ctl,
    input  t_word            i_a,
    input  t_word            i_b,
    output logic [ACC_W-1:0] o_acc
);

    logic [31:0]      a_half;
    logic [31:0]      b_half;
    logic [63:0]      r_prod;
    logic [1:0]       r_sum;
    logic [ACC_W-1:0] r_acc;

    assign a_half = i_ctl.pp[0] ? i_a[63:32] : i_a[31:0];
    assign b_half = i_ctl.pp[1] ? i_b[63:32] : i_b[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= a_half * b_half;
            r_sum  <= {1'b0, i_ctl.pp[0]} + {1'b0, i_ctl.pp[1]};
        end
        if (i_ctl.init) begin
            r_acc <= ACC_W'(i_ctl.rnd) << i_ctl.rnd_pos;
        end else if (i_ctl.add) begin
            // partial weight is 2^(32 * number of high halves)
            r_acc <= r_acc + (ACC_W'(r_prod) << {r_sum, 5'b0});
        end
    end

    assign o_acc = r_acc;

endmodule

### hdl/motor_feedback_multiturn_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder
// Each input word is either a feedback frame or a time check. A frame updates
// the turn counter (a code jump beyond 4096 counts one turn) and yields angle,
// speed and torque as rounded, saturated signed values, the angle in Q32.16
// and speed and torque in Q16.16. All products run through one 32x32
// multiplier in six steps (three exact, three of four partial products); each
// partial passes a multiply and an accumulate state, and each step ends in a
// store state. The next word is taken only after the result is registered. A
// time check goes straight to the result with zero angle, speed, torque and
// temperature. Ready stays low while a word is in work.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_decoder
    import mfmd_pkg::*;
#(
    parameter int TURN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [31:0]           i_time_ms,
    input  logic [12:0]           i_angle_code,
    input  logic signed [15:0]    i_speed_rpm,
    input  logic signed [15:0]    i_current_raw,
    input  logic [7:0]            i_temperature,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [47:0]    o_angle_q16,
    output logic signed [31:0]    o_speed_q16,
    output logic signed [31:0]    o_torque_q16,
    output logic [7:0]            o_temperature_c,
    output logic signed [15:0]    o_turn_count,
    output logic                  o_opened,
    output logic                  o_alive
);

    localparam int ANG_W      = TURN_BITS + CODE_BITS + 1;
    localparam int TURN_EXT_W = (TURN_BITS > TURN_OUT_W) ? TURN_BITS : TURN_OUT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // odd steps are the wide rounded products
    localparam logic [2:0] OP_K     = 3'd0;
    localparam logic [2:0] OP_ANG   = 3'd1;
    localparam logic [2:0] OP_SPD_M = 3'd2;
    localparam logic [2:0] OP_SPD   = 3'd3;
    localparam logic [2:0] OP_TQ_M  = 3'd4;
    localparam logic [2:0] OP_TQ    = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_op;
    logic [1:0]  r_pp;

    logic [1:0]  r_motor_type;
    logic [15:0] r_ratio;
    logic [23:0] r_inv_ratio;
    logic        r_multi;
    logic [15:0] r_window;

    logic                 r_seen;
    logic [12:0]          r_prev_code;
    logic [TURN_BITS-1:0] r_turns;
    logic [31:0]          r_last_time;

    logic        r_time_chk;
    logic [12:0] r_code;
    logic [7:0]  r_temp;
    logic        r_rpm_neg;
    logic [15:0] r_rpm_mag;
    logic        r_cur_neg;
    logic [15:0] r_cur_mag;
    logic        r_alive;

    logic             r_ang_neg;
    logic [ANG_W-1:0] r_ang_mag;
    logic [M_W-1:0]   r_m;
    logic [47:0]      r_ang_res;
    logic [31:0]      r_spd_res;
    logic [31:0]      r_tq_res;

    logic        r_out_valid;
    logic [47:0] r_out_angle;
    logic [31:0] r_out_speed;
    logic [31:0] r_out_torque;
    logic [7:0]  r_out_temp;
    logic [15:0] r_out_turns;
    logic        r_out_opened;
    logic        r_out_alive;

    logic                  accept;
    logic                  out_load;
    logic [12:0]           prev_eff;
    logic signed [13:0]    diff;
    logic [TURN_BITS-1:0]  n_turns;
    logic                  n_seen;
    logic [31:0]           n_last;
    logic [31:0]           age;
    logic signed [ANG_W-1:0] code_off;
    logic signed [ANG_W-1:0] turn_off;
    logic signed [ANG_W-1:0] total;
    logic [TURN_EXT_W-1:0] turns_ext;

    t_word            mac_a;
    t_word            mac_b;
    t_mac_ctl         mac_ctl;
    logic [ACC_W-1:0] mac_acc;
    logic             pp_last;
    logic [2:0]       nxt_op;

    logic [ACC_W-1:0] q_ang;
    logic [ACC_W-1:0] q_rate;
    logic [ACC_W-1:0] ang_lim;
    logic [ACC_W-1:0] rate_lim;
    logic [ACC_W-1:0] ang_sat;
    logic [ACC_W-1:0] rate_sat;
    logic             rate_neg;

    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // turn tracking; the first frame only seeds the previous code
    assign prev_eff = r_seen ? r_prev_code : i_angle_code;
    assign diff     = signed'({1'b0, i_angle_code}) - signed'({1'b0, prev_eff});

    always_comb begin
        n_turns = r_turns;
        if (diff > JUMP_LIM) begin
            n_turns = r_turns - TURN_BITS'(1);
        end else if (diff < -JUMP_LIM) begin
            n_turns = r_turns + TURN_BITS'(1);
        end
    end

    assign n_seen = r_seen || !i_cmd;
    assign n_last = i_cmd ? r_last_time : i_time_ms;
    assign age    = i_time_ms - n_last;

    // angle before scaling, in codes
    assign code_off = ANG_W'(signed'({1'b0, r_code})) - ANG_W'(ANG_OFFSET);
    assign turn_off = r_multi ? (ANG_W'(signed'(r_turns)) <<< CODE_BITS) : '0;
    assign total    = code_off + turn_off;

    always_comb begin
        case (r_op)
            OP_K: begin
                mac_a = t_word'(r_inv_ratio);
                mac_b = t_word'(PI_Q30);
            end
            OP_ANG: begin
                mac_a = t_word'(r_ang_mag);
                mac_b = t_word'(r_m);
            end
            OP_SPD_M: begin
                mac_a = t_word'(r_rpm_mag);
                mac_b = t_word'(r_inv_ratio);
            end
            OP_SPD: begin
                mac_a = t_word'(r_m);
                mac_b = t_word'(OMEGA_Q40);
            end
            OP_TQ_M: begin
                mac_a = t_word'(r_cur_mag);
                mac_b = t_word'(r_ratio);
            end
            OP_TQ: begin
                mac_a = t_word'(r_m);
                mac_b = torque_factor(r_motor_type);
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    assign pp_last = r_op[0] ? (r_pp == 2'd3) : (r_pp == 2'd0);
    assign nxt_op  = (r_state == S_PREP) ? OP_K : (r_op + 3'd1);

    always_comb begin
        mac_ctl.init    = (r_state == S_PREP) || ((r_state == S_STORE) && (r_op != OP_TQ));
        mac_ctl.rnd     = nxt_op[0];
        mac_ctl.rnd_pos = (nxt_op == OP_ANG) ? 6'(ANG_SH - 1) : 6'(RATE_SH - 1);
        mac_ctl.mul     = (r_state == S_MUL);
        mac_ctl.add     = (r_state == S_ACC);
        mac_ctl.pp      = r_pp;
    end

    mfmd_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // rounding bit was preloaded, so a plain shift rounds half away from zero
    assign q_ang    = mac_acc >> ANG_SH;
    assign q_rate   = mac_acc >> RATE_SH;
    assign rate_neg = (r_op == OP_SPD) ? r_rpm_neg : r_cur_neg;
    assign ang_lim  = ACC_W'(ANG_HALF) - ACC_W'(!r_ang_neg);
    assign rate_lim = ACC_W'(OUT_HALF) - ACC_W'(!rate_neg);
    assign ang_sat  = (q_ang > ang_lim) ? ang_lim : q_ang;
    assign rate_sat = (q_rate > rate_lim) ? rate_lim : q_rate;

    assign turns_ext = TURN_EXT_W'(r_turns);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_cmd ? S_DONE : S_PREP;
                end
            end
            S_PREP:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = pp_last ? S_STORE : S_MUL;
            S_STORE: n_state = (r_op == OP_TQ) ? S_DONE : S_MUL;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_K;
            r_pp         <= 2'd0;
            r_motor_type <= MT_LARGE;
            r_ratio      <= 16'd256;
            r_inv_ratio  <= 24'd65536;
            r_multi      <= 1'b0;
            r_window     <= 16'd100;
            r_seen       <= 1'b0;
            r_prev_code  <= '0;
            r_turns      <= '0;
            r_last_time  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOTOR_TYPE: r_motor_type <= i_cfg_data[1:0];
                    CFG_RATIO:      r_ratio      <= i_cfg_data[15:0];
                    CFG_INV_RATIO:  r_inv_ratio  <= i_cfg_data[23:0];
                    CFG_MULTI_TURN: r_multi      <= i_cfg_data[0];
                    CFG_WINDOW:     r_window     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (accept && !i_cmd) begin
                r_seen      <= 1'b1;
                r_prev_code <= i_angle_code;
                r_turns     <= n_turns;
                r_last_time <= i_time_ms;
            end

            if (r_state == S_PREP) begin
                r_op <= OP_K;
                r_pp <= 2'd0;
            end else if (r_state == S_ACC) begin
                r_pp <= pp_last ? 2'd0 : (r_pp + 2'd1);
            end else if (r_state == S_STORE) begin
                r_op <= nxt_op;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time_chk <= i_cmd;
            r_code     <= i_angle_code;
            r_temp     <= i_temperature;
            r_rpm_neg  <= i_speed_rpm[15];
            r_rpm_mag  <= i_speed_rpm[15] ? 16'(-i_speed_rpm) : i_speed_rpm;
            r_cur_neg  <= i_current_raw[15];
            r_cur_mag  <= i_current_raw[15] ? 16'(-i_current_raw) : i_current_raw;
            r_alive    <= n_seen && (age < {16'd0, r_window});
        end

        if (r_state == S_PREP) begin
            r_ang_neg <= total[ANG_W-1];
            r_ang_mag <= total[ANG_W-1] ? ANG_W'(-total) : ANG_W'(total);
        end

        if (r_state == S_STORE) begin
            case (r_op)
                OP_ANG:  r_ang_res <= ang_sat[47:0];
                OP_SPD:  r_spd_res <= rate_sat[31:0];
                OP_TQ:   r_tq_res  <= rate_sat[31:0];
                default: r_m       <= mac_acc[M_W-1:0];
            endcase
        end

        if (out_load) begin
            if (r_time_chk) begin
                r_out_angle  <= '0;
                r_out_speed  <= '0;
                r_out_torque <= '0;
                r_out_temp   <= '0;
            end else begin
                r_out_angle  <= r_ang_neg ? (48'd0 - r_ang_res) : r_ang_res;
                r_out_speed  <= r_rpm_neg ? (32'd0 - r_spd_res) : r_spd_res;
                r_out_torque <= r_cur_neg ? (32'd0 - r_tq_res) : r_tq_res;
                r_out_temp   <= r_temp;
            end
            r_out_turns  <= turns_ext[TURN_OUT_W-1:0];
            r_out_opened <= r_seen;
            r_out_alive  <= r_alive;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_angle_q16     = r_out_angle;
    assign o_speed_q16     = r_out_speed;
    assign o_torque_q16    = r_out_torque;
    assign o_temperature_c = r_out_temp;
    assign o_turn_count    = r_out_turns;
    assign o_opened        = r_out_opened;
    assign o_alive         = r_out_alive;

endmodule

### hdl/mfmd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmd_chk
// port level checks for the motor feedback decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "motor_feedback_multiturn_decoder_macros.svh"

module mfmd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_turn_count,
    input logic               o_opened,
    input logic               o_alive
);

    // a stalled result word stays offered
    `MFMD_ASSERT_CLK(a_out_hold, o_valid && !i_ready |=> o_valid, "result word dropped while stalled")

    // one word in work at a time
    `MFMD_ASSERT_CLK(a_busy_after_accept, i_valid && o_ready |=> !o_ready, "ready high right after accept")

    // alive needs a frame seen
    `MFMD_ASSERT_CLK(a_alive_opened, o_valid && o_alive |-> o_opened, "alive without any frame")

    // turns move only on frames
    `MFMD_ASSERT_CLK(a_turns_idle, o_valid && !o_opened |-> o_turn_count == 16'sd0, "turns before first frame")

endmodule

bind motor_feedback_multiturn_decoder mfmd_chk u_mfmd_chk (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the motor feedback multiturn decoder. A driver sends frame and
// time-check words from a queue while a monitor predicts each decoded word
// (turn counting, scaled Q16.16 angle, speed and torque, liveness) and checks
// it against the block's output in order. Both sides idle and stall at random,
// and the configuration is swept between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import mfmd_pkg::*;

    localparam logic CMD_FRAME      = 1'b0;
    localparam logic CMD_TIME_CHECK = 1'b1;

    localparam logic [1:0] MT_GIMBAL_CUR  = 2'd2;
    localparam logic [1:0] MT_GIMBAL_VOLT = 2'd3;

    localparam int     TURN_JUMP      = 4096;
    localparam longint CODE_CENTER    = 4095;
    localparam longint CODES_PER_TURN = 8192;

    // 2*pi as round(pi * 2^30) / 2^29, pi/30 scaled by 2^40
    localparam logic [63:0] ANGLE_K = 64'd3373259426;
    localparam logic [63:0] RPM_K   = 64'd115140588411;
    localparam int          ANGLE_SHIFT = 42;
    localparam int          RATE_SHIFT  = 40;

    // torque per raw current unit, scaled by 2^48
    localparam logic [63:0] TQF_SMALL  = (((64'd1 << 49) / 64'd200000) + 64'd1) / 64'd2;
    localparam logic [63:0] TQF_LARGE  = (((64'd1122 << 35) / 64'd3591) + 64'd1) / 64'd2;
    localparam logic [63:0] TQF_GIMBAL = (((64'd2223 << 35) / 64'd1000) + 64'd1) / 64'd2;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic               cmd;
        logic [31:0]        tstamp;
        logic [12:0]        code;
        logic [15:0]        rpm;
        logic [15:0]        current;
        logic [7:0]         temp;
    } t_feedback;

    typedef struct packed {
        logic [47:0] angle;
        logic [31:0] speed;
        logic [31:0] torque;
        logic [7:0]  temp;
        logic [15:0] turns;
        logic        opened;
        logic        alive;
    } t_decoded;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      in_valid = 1'b0;
    logic      o_ready;
    t_feedback drv_word = '0;

    logic               o_valid;
    logic               out_ready = 1'b0;
    logic signed [47:0] o_angle_q16;
    logic signed [31:0] o_speed_q16;
    logic signed [31:0] o_torque_q16;
    logic [7:0]         o_temperature_c;
    logic signed [15:0] o_turn_count;
    logic               o_opened;
    logic               o_alive;

    motor_feedback_multiturn_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_ready         (o_ready),
        .i_cmd           (drv_word.cmd),
        .i_time_ms       (drv_word.tstamp),
        .i_angle_code    (drv_word.code),
        .i_speed_rpm     (drv_word.rpm),
        .i_current_raw   (drv_word.current),
        .i_temperature   (drv_word.temp),
        .o_valid         (o_valid),
        .i_ready         (out_ready),
        .o_angle_q16     (o_angle_q16),
        .o_speed_q16     (o_speed_q16),
        .o_torque_q16    (o_torque_q16),
        .o_temperature_c (o_temperature_c),
        .o_turn_count    (o_turn_count),
        .o_opened        (o_opened),
        .o_alive         (o_alive)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // predictor copy of configuration and state
    logic [1:0]  cf_type   = MT_LARGE;
    logic [15:0] cf_ratio  = 16'd256;
    logic [23:0] cf_inv    = 24'd65536;
    logic        cf_multi  = 1'b0;
    logic [15:0] cf_window = 16'd100;

    logic        pr_seen      = 1'b0;
    logic [12:0] pr_prev_code = '0;
    logic [15:0] pr_turns     = '0;
    logic [31:0] pr_last_time = '0;

    t_feedback feedback_q[$];
    t_decoded  decoded_q[$];

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    bit hold_used = 1'b0;
    bit in_hs = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int mismatches = 0;
    int n_frames = 0;
    int n_checks = 0;
    int n_results = 0;
    int n_alive = 0;
    int turn_lo = 0;
    int turn_hi = 0;

    // stimulus generator state
    logic [12:0] gen_code = '0;
    logic [31:0] gen_time = '0;
    int          gen_dir = 1;

    // round(mag * k / 2^sh) half away from zero, saturated to a signed w-bit value
    function automatic logic [63:0] round_scale_sat(input logic neg, input logic [63:0] mag,
                                                    input logic [63:0] k, input int sh,
                                                    input int w);
        logic [127:0] prod;
        logic [127:0] half;
        prod = {64'd0, mag} * {64'd0, k};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        half = 128'd1 << (w - 1);
        if (neg) begin
            if (prod > half) prod = half;
            prod = (128'd0 - prod) & ((128'd1 << w) - 128'd1);
        end else if (prod > half - 128'd1) begin
            prod = half - 128'd1;
        end
        return prod[63:0];
    endfunction

    function automatic t_decoded decode_feedback(input t_feedback f);
        t_decoded    r;
        int          jump;
        longint      pos;
        longint      spd;
        longint      amp;
        logic [63:0] factor;
        logic [31:0] elapsed;
        r = '0;
        if (f.cmd == CMD_FRAME) begin
            pr_last_time = f.tstamp;
            if (!pr_seen) begin
                pr_seen = 1'b1;
                pr_prev_code = f.code;
            end
            jump = int'(f.code) - int'(pr_prev_code);
            if (jump > TURN_JUMP) pr_turns = pr_turns - 16'd1;
            else if (jump < -TURN_JUMP) pr_turns = pr_turns + 16'd1;
            pr_prev_code = f.code;

            pos = longint'(f.code) - CODE_CENTER;
            if (cf_multi) pos = pos + longint'($signed(pr_turns)) * CODES_PER_TURN;
            r.angle = 48'(round_scale_sat(pos < 0, pos < 0 ? -pos : pos,
                                          64'(cf_inv) * ANGLE_K, ANGLE_SHIFT, 48));

            spd = $signed(f.rpm);
            r.speed = 32'(round_scale_sat(spd < 0, 64'(spd < 0 ? -spd : spd) * 64'(cf_inv),
                                          RPM_K, RATE_SHIFT, 32));

            case (cf_type)
                MT_SMALL: factor = TQF_SMALL;
                MT_LARGE: factor = TQF_LARGE;
                default:  factor = TQF_GIMBAL;
            endcase
            amp = $signed(f.current);
            r.torque = 32'(round_scale_sat(amp < 0, 64'(amp < 0 ? -amp : amp) * 64'(cf_ratio),
                                           factor, RATE_SHIFT, 32));
            r.temp = f.temp;
        end
        r.turns = pr_turns;
        r.opened = pr_seen;
        elapsed = f.tstamp - pr_last_time;
        r.alive = pr_seen && (elapsed < 32'(cf_window));
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [15:0] pick_s16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic cmd, input logic [31:0] stamp, input logic [12:0] code,
                             input logic [15:0] rpm, input logic [15:0] current,
                             input logic [7:0] temp);
        feedback_q.push_back('{cmd, stamp, code, rpm, current, temp});
    endtask

    task automatic push_random();
        t_feedback f;
        int        kind;
        int        step;
        int        span;
        kind = $urandom_range(0, 99);
        span = 2 * int'(cf_window) + 2;
        case ($urandom_range(0, 19))
            0:       gen_time = $urandom;
            1, 2, 3: gen_time = gen_time + $urandom_range(0, 3);
            default: gen_time = gen_time + $urandom_range(0, span);
        endcase
        if ($urandom_range(0, 29) == 0) gen_dir = -gen_dir;
        f.cmd = (kind < 12) ? CMD_TIME_CHECK : CMD_FRAME;
        f.tstamp = gen_time;
        if (kind < 24) begin
            f.code = 13'($urandom);
        end else begin
            // rotating shaft: steady steps in one direction, now and then a wild one
            step = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 8191 : 3000);
            f.code = 13'(int'(gen_code) + step * gen_dir);
        end
        if (f.cmd == CMD_FRAME) gen_code = f.code;
        f.rpm = pick_s16();
        f.current = pick_s16();
        f.temp = 8'($urandom);
        feedback_q.push_back(f);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MOTOR_TYPE: cf_type = val[1:0];
            CFG_RATIO:      cf_ratio = val[15:0];
            CFG_INV_RATIO:  cf_inv = val[23:0];
            CFG_MULTI_TURN: cf_multi = val[0];
            CFG_WINDOW:     cf_window = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (feedback_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [1:0] mt, input int ratio, input int inv,
                             input bit multi, input int win, input int n, input bit idle,
                             input bit hold, input logic [31:0] t0);
        wait_drained();
        cfg_write(CFG_MOTOR_TYPE, CFG_DATA_W'(mt));
        cfg_write(CFG_RATIO, CFG_DATA_W'(ratio));
        cfg_write(CFG_INV_RATIO, CFG_DATA_W'(inv));
        cfg_write(CFG_MULTI_TURN, CFG_DATA_W'(multi));
        cfg_write(CFG_WINDOW, CFG_DATA_W'(win));
        @(negedge clk);
        cfg_we <= 1'b0;
        idle_on = idle;
        hold_req = hold;
        gen_time = t0;
        repeat (n) push_random();
    endtask

    task automatic log_mismatch(input string what, input t_decoded want, input t_decoded got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  exp ang=%0d spd=%0d tq=%0d temp=%0d turns=%0d open=%0b alive=%0b",
                     $signed(want.angle), $signed(want.speed), $signed(want.torque),
                     want.temp, $signed(want.turns), want.opened, want.alive);
            $display("  got ang=%0d spd=%0d tq=%0d temp=%0d turns=%0d open=%0b alive=%0b",
                     $signed(got.angle), $signed(got.speed), $signed(got.torque),
                     got.temp, $signed(got.turns), got.opened, got.alive);
        end
    endtask

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_hs) begin
            in_valid <= 1'b1;
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (feedback_q.size() != 0) begin
            drv_word <= feedback_q.pop_front();
            in_valid <= 1'b1;
            gap_left <= pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
        end
    end

    // monitor: predicts on every accepted word, checks every delivered result
    always @(posedge clk) begin : monitor
        t_decoded got;
        t_decoded want;
        if (!rst_n) begin
            in_hs <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_hs <= in_valid && o_ready;
            if (o_valid && out_ready) begin
                got = '{o_angle_q16, o_speed_q16, o_torque_q16, o_temperature_c,
                        o_turn_count, o_opened, o_alive};
                n_results++;
                if (decoded_q.size() == 0) begin
                    log_mismatch("result word with nothing expected", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.angle !== want.angle || got.speed !== want.speed ||
                        got.torque !== want.torque || got.temp !== want.temp ||
                        got.turns !== want.turns || got.opened !== want.opened ||
                        got.alive !== want.alive)
                        log_mismatch("result word mismatch", want, got);
                end
            end
            if (in_valid && o_ready) begin
                want = decode_feedback(drv_word);
                decoded_q.push_back(want);
                if (drv_word.cmd == CMD_FRAME) n_frames++;
                else n_checks++;
                if (want.alive) n_alive++;
                if ($signed(want.turns) < turn_lo) turn_lo = $signed(want.turns);
                if ($signed(want.turns) > turn_hi) turn_hi = $signed(want.turns);
            end
            if ((in_valid && o_ready) || (o_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under reset configuration (window 100, single turn)
        push_word(CMD_TIME_CHECK, 32'd50, 13'd0, 16'h0000, 16'h0000, 8'd0);
        push_word(CMD_FRAME, 32'd1000, 13'd0, 16'h7fff, 16'h7fff, 8'd255);
        push_word(CMD_FRAME, 32'd1050, 13'd8191, 16'h8000, 16'h8000, 8'd0);
        push_word(CMD_FRAME, 32'd1099, 13'd0, 16'h0001, 16'hffff, 8'd1);
        // a jump of exactly 4096 either way is not a turn
        push_word(CMD_FRAME, 32'd1100, 13'd4096, 16'h1234, 16'hedcb, 8'd128);
        push_word(CMD_FRAME, 32'd1110, 13'd0, 16'hedcb, 16'h1234, 8'd127);
        push_word(CMD_FRAME, 32'd1120, 13'd4097, 16'h5555, 16'haaaa, 8'd85);
        push_word(CMD_FRAME, 32'd1130, 13'd0, 16'haaaa, 16'h5555, 8'd170);
        push_word(CMD_FRAME, 32'd1200, 13'd4095, 16'h0000, 16'h0000, 8'd25);
        // liveness at both sides of the window edge
        push_word(CMD_TIME_CHECK, 32'd1299, 13'd8191, 16'hffff, 16'hffff, 8'd255);
        push_word(CMD_TIME_CHECK, 32'd1300, 13'd0, 16'h0000, 16'h0000, 8'd0);
        // timestamp wrap across 2^32
        push_word(CMD_FRAME, 32'hffff_fff0, 13'd8191, 16'h0001, 16'hffff, 8'd60);
        push_word(CMD_TIME_CHECK, 32'h0000_0050, 13'd0, 16'h0000, 16'h0000, 8'd0);
        push_word(CMD_TIME_CHECK, 32'h0000_0060, 13'd0, 16'h0000, 16'h0000, 8'd0);
        push_word(CMD_FRAME, 32'h0000_0070, 13'd1, 16'hffff, 16'h0001, 8'd70);
        push_word(CMD_FRAME, 32'h0000_0080, 13'd8190, 16'h8001, 16'h7ffe, 8'd80);
        gen_code = 13'd8190;

        run_phase(MT_LARGE, 256, 65536, 1'b0, 100, 250, 1'b1, 1'b0, 32'd5000);
        // largest ratios, shortest window: saturation everywhere
        run_phase(MT_SMALL, 65535, 16777215, 1'b1, 1, 250, 1'b1, 1'b0, 32'd9000);
        run_phase(MT_GIMBAL_CUR, 1, 1, 1'b0, 65535, 200, 1'b0, 1'b0, 32'hffff_0000);
        // zero ratios and zero window
        run_phase(MT_GIMBAL_VOLT, 0, 0, 1'b1, 0, 150, 1'b1, 1'b0, 32'd0);
        run_phase(2'($urandom), $urandom_range(1, 65535), $urandom_range(1, 16777215), 1'b1,
                  $urandom_range(1, 65535), 300, 1'b1, 1'b1, $urandom);
        run_phase(MT_LARGE, 2304, 7282, 1'b1, 200, 300, 1'b1, 1'b0, 32'hffff_f000);
        run_phase(2'($urandom), $urandom_range(0, 65535), $urandom_range(0, 16777215),
                  1'($urandom), $urandom_range(0, 300), 250, 1'b0, 1'b0, $urandom);

        wait_drained();
        repeat (60) @(posedge clk);
        if (decoded_q.size() != 0) begin
            mismatches++;
            $display("%0d expected result words never arrived", decoded_q.size());
        end
        $display("covered %0d frames and %0d time checks, %0d results checked, %0d alive",
                 n_frames, n_checks, n_results, n_alive);
        $display("turn count ranged %0d..%0d over 8 register settings, %0d mismatches",
                 turn_lo, turn_hi, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/mfmd_pkg.sv
hdl/mfmd_mac.sv
hdl/motor_feedback_multiturn_decoder.sv
hdl/mfmd_chk.sv
tb/tb_top.sv
